### rtl/mfd_pkg.sv
// shared constants, types and command structs for the motor feedback frame decoder
`timescale 1ns / 1ps

package mfd_pkg;

  // motor slots and identifier layout
  localparam int MotorSlots = 8;
  localparam int SlotW      = 3;
  localparam logic [10:0] IdBase = 11'h200;

  // field widths
  localparam int IdW      = 11;
  localparam int PayloadW = 64;
  localparam int NumW     = 4;
  localparam int AngleW   = 17;
  localparam int TempW    = 8;
  localparam int TurnW    = 32;
  localparam int MaskW    = 8;
  localparam int CfgW     = 32;

  // multi-turn position and multiplier widths
  localparam int MtW     = 46;
  localparam int MtLoW   = 24;
  localparam int OpaW    = 25;
  localparam int OpbW    = 33;
  localparam int ProdW   = OpaW + OpbW;
  localparam int PloW    = 56;
  localparam int WideW   = 64;
  localparam int TurnShift = 13;

  // configuration port
  localparam int AddrW = 4;
  localparam logic [1:0] RegRegisteredMask = 2'd0;
  localparam logic [1:0] RegReverseMask    = 2'd1;
  localparam logic [1:0] RegInvRatio       = 2'd2;
  localparam logic [1:0] RegTorqueGain     = 2'd3;
  localparam logic [CfgW-1:0] InvRatioReset = 32'h0001_0000;

  // result status codes
  localparam logic StatusDecoded      = 1'b0;
  localparam logic StatusNotRegistered = 1'b1;

  // stored speed sign codes
  localparam logic [1:0] SignZero = 2'b00;
  localparam logic [1:0] SignPos  = 2'b01;
  localparam logic [1:0] SignNeg  = 2'b11;

  // operand pair for the shared multiplier
  typedef enum logic [1:0] {
    MUL_SPEED   = 2'd0,
    MUL_CURRENT = 2'd1,
    MUL_MT_LO   = 2'd2,
    MUL_MT_HI   = 2'd3
  } mul_op_e;

  // configuration register contents
  typedef struct packed {
    logic [MaskW-1:0] reg_mask;
    logic [MaskW-1:0] rev_mask;
    logic [CfgW-1:0]  inv_ratio;
    logic [CfgW-1:0]  trq_gain;
  } mfd_cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic    load_in;
    logic    dec;
    mul_op_e mul_op;
    logic    st_spd;
    logic    st_trq;
    logic    st_plo;
    logic    fin;
  } mfd_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic hit;
  } mfd_stat_t;

endpackage

### rtl/mfd_regs.sv
// configuration register file behind the apb-style port
`timescale 1ns / 1ps

module mfd_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mfd_pkg::AddrW-1:0]   paddr,
  input  logic [mfd_pkg::CfgW-1:0]    pwdata,
  output logic [mfd_pkg::CfgW-1:0]    prdata,
  output logic                        pready,
  output mfd_pkg::mfd_cfg_t           cfg_o
);

  mfd_pkg::mfd_cfg_t cfg_q;
  logic [1:0]        reg_idx;
  logic              wr_en;

  assign reg_idx = paddr[mfd_pkg::AddrW-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  // register writes on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reg_mask  <= '0;
      cfg_q.rev_mask  <= '0;
      cfg_q.inv_ratio <= mfd_pkg::InvRatioReset;
      cfg_q.trq_gain  <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        mfd_pkg::RegRegisteredMask: cfg_q.reg_mask  <= pwdata[mfd_pkg::MaskW-1:0];
        mfd_pkg::RegReverseMask:    cfg_q.rev_mask  <= pwdata[mfd_pkg::MaskW-1:0];
        mfd_pkg::RegInvRatio:       cfg_q.inv_ratio <= pwdata;
        mfd_pkg::RegTorqueGain:     cfg_q.trq_gain  <= pwdata;
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      mfd_pkg::RegRegisteredMask: prdata = mfd_pkg::CfgW'(cfg_q.reg_mask);
      mfd_pkg::RegReverseMask:    prdata = mfd_pkg::CfgW'(cfg_q.rev_mask);
      mfd_pkg::RegInvRatio:       prdata = cfg_q.inv_ratio;
      mfd_pkg::RegTorqueGain:     prdata = cfg_q.trq_gain;
      default:                    prdata = '0;
    endcase
  end

endmodule

### rtl/mfd_ctrl.sv
// controller state machine sequencing decode and the shared multiplier
`timescale 1ns / 1ps

module mfd_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  mfd_pkg::mfd_stat_t stat_i,
  output mfd_pkg::mfd_cmd_t  cmd_o,
  output logic               busy_o
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_DEC  = 7'b0000010,
    ST_SPD  = 7'b0000100,
    ST_TRQ  = 7'b0001000,
    ST_PLO  = 7'b0010000,
    ST_PHI  = 7'b0100000,
    ST_FIN  = 7'b1000000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  assign busy_o = (state_q != ST_IDLE);

  // next state and commands
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.mul_op   = mfd_pkg::MUL_SPEED;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load_in = start_i;
        if (start_i) state_d = ST_DEC;
      end
      ST_DEC: begin
        cmd_o.dec = 1'b1;
        state_d   = stat_i.hit ? ST_SPD : ST_FIN;
      end
      ST_SPD: begin
        cmd_o.mul_op = mfd_pkg::MUL_SPEED;
        state_d      = ST_TRQ;
      end
      ST_TRQ: begin
        cmd_o.mul_op = mfd_pkg::MUL_CURRENT;
        cmd_o.st_spd = 1'b1;
        state_d      = ST_PLO;
      end
      ST_PLO: begin
        cmd_o.mul_op = mfd_pkg::MUL_MT_LO;
        cmd_o.st_trq = 1'b1;
        state_d      = ST_PHI;
      end
      ST_PHI: begin
        cmd_o.mul_op = mfd_pkg::MUL_MT_HI;
        cmd_o.st_plo = 1'b1;
        state_d      = ST_FIN;
      end
      ST_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/mfd_dpath.sv
// datapath: frame unpacking, per-motor turn tracking, shared multiplier, result registers
`timescale 1ns / 1ps

module mfd_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mfd_pkg::mfd_cmd_t                   cmd_i,
  output mfd_pkg::mfd_stat_t                  stat_o,
  input  mfd_pkg::mfd_cfg_t                   cfg_i,
  input  logic [mfd_pkg::IdW-1:0]             frame_id_i,
  input  logic [mfd_pkg::PayloadW-1:0]        payload_i,
  output logic                                valid_o,
  output logic                                status_o,
  output logic [mfd_pkg::NumW-1:0]            motor_number_o,
  output logic signed [mfd_pkg::AngleW-1:0]   rotor_angle_o,
  output logic signed [mfd_pkg::AngleW-1:0]   rotor_speed_o,
  output logic signed [mfd_pkg::AngleW-1:0]   winding_current_o,
  output logic [mfd_pkg::TempW-1:0]           temperature_o,
  output logic signed [mfd_pkg::TurnW-1:0]    turn_count_o,
  output logic signed [mfd_pkg::WideW-1:0]    shaft_position_o,
  output logic signed [mfd_pkg::CfgW-1:0]     shaft_speed_o,
  output logic signed [mfd_pkg::WideW-1:0]    torque_o
);

  // captured frame
  logic [mfd_pkg::IdW-1:0]      id_q;
  logic [mfd_pkg::PayloadW-1:0] pay_q;

  // per-motor tracking state
  logic signed [mfd_pkg::AngleW-1:0] last_angle_q [mfd_pkg::MotorSlots];
  logic signed [mfd_pkg::TurnW-1:0]  turn_arr_q   [mfd_pkg::MotorSlots];
  logic [1:0]                        sign_arr_q   [mfd_pkg::MotorSlots];

  // decoded item
  logic                               hit_q;
  logic [mfd_pkg::NumW-1:0]           num_q;
  logic signed [mfd_pkg::AngleW-1:0]  angle_q, speed_q, current_q;
  logic [mfd_pkg::TempW-1:0]          temp_q;
  logic signed [mfd_pkg::TurnW-1:0]   turn_q;
  logic signed [mfd_pkg::MtW-1:0]     mt_q;

  // multiplier and partial results
  logic signed [mfd_pkg::ProdW-1:0]   prod_q;
  logic signed [mfd_pkg::CfgW-1:0]    spd_q;
  logic signed [mfd_pkg::WideW-1:0]   trq_q;
  logic [mfd_pkg::PloW-1:0]           plo_q;
  logic                               valid_q;

  // decode signals
  logic [mfd_pkg::IdW-1:0]            diff;
  logic [mfd_pkg::SlotW-1:0]          slot;
  logic                               hit;
  logic                               rev;
  logic signed [mfd_pkg::AngleW-1:0]  angle_raw, speed_raw, current_raw;
  logic signed [mfd_pkg::AngleW-1:0]  angle_d, speed_d, current_d;
  logic signed [mfd_pkg::AngleW-1:0]  last_a;
  logic [1:0]                         last_s;
  logic signed [mfd_pkg::TurnW-1:0]   turn_old, turn_new;
  logic [1:0]                         sign_new;
  logic signed [mfd_pkg::MtW-1:0]     mt_d;
  logic signed [mfd_pkg::OpaW-1:0]    opa;
  logic signed [mfd_pkg::OpbW-1:0]    opb;
  logic                               spd_fits;
  logic signed [mfd_pkg::CfgW-1:0]    spd_sat;
  logic signed [mfd_pkg::WideW-1:0]   pos_d;

  // motor number, slot and mask check
  assign diff = id_q - mfd_pkg::IdBase;
  assign slot = mfd_pkg::SlotW'(diff - 1'b1);
  assign hit  = (diff >= mfd_pkg::IdW'(1)) && (diff <= mfd_pkg::IdW'(mfd_pkg::MotorSlots))
                && cfg_i.reg_mask[slot];
  assign stat_o.hit = hit;
  assign rev  = cfg_i.rev_mask[slot];

  // payload unpacking with direction applied
  assign angle_raw   = signed'({1'b0, pay_q[63:48]});
  assign speed_raw   = signed'({pay_q[47], pay_q[47:32]});
  assign current_raw = signed'({pay_q[31], pay_q[31:16]});
  assign angle_d     = rev ? -angle_raw : angle_raw;
  assign speed_d     = rev ? -speed_raw : speed_raw;
  assign current_d   = rev ? -current_raw : current_raw;

  // turn tracking
  assign last_a   = last_angle_q[slot];
  assign last_s   = sign_arr_q[slot];
  assign turn_old = turn_arr_q[slot];

  always_comb begin
    if ((angle_d > last_a) && (last_s == mfd_pkg::SignNeg)) begin
      turn_new = turn_old - 32'sd1;
    end else if ((angle_d < last_a) && (last_s == mfd_pkg::SignPos)) begin
      turn_new = turn_old + 32'sd1;
    end else begin
      turn_new = turn_old;
    end
    if (speed_d > 17'sd0) begin
      sign_new = mfd_pkg::SignPos;
    end else if (speed_d < 17'sd0) begin
      sign_new = mfd_pkg::SignNeg;
    end else begin
      sign_new = mfd_pkg::SignZero;
    end
  end

  // multi-turn count: turn * 8191 + angle, done as shift and subtract
  assign mt_d = (mfd_pkg::MtW'(turn_new) <<< mfd_pkg::TurnShift) - mfd_pkg::MtW'(turn_new)
                + mfd_pkg::MtW'(angle_d);

  // frame capture on accept
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      id_q  <= frame_id_i;
      pay_q <= payload_i;
    end
  end

  // per-motor state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mfd_pkg::MotorSlots; i++) begin
        last_angle_q[i] <= '0;
        turn_arr_q[i]   <= '0;
        sign_arr_q[i]   <= mfd_pkg::SignZero;
      end
    end else if (cmd_i.dec && hit) begin
      last_angle_q[slot] <= angle_d;
      turn_arr_q[slot]   <= turn_new;
      sign_arr_q[slot]   <= sign_new;
    end
  end

  // decoded item registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.dec) begin
      hit_q     <= hit;
      num_q     <= diff[mfd_pkg::NumW-1:0];
      angle_q   <= angle_d;
      speed_q   <= speed_d;
      current_q <= current_d;
      temp_q    <= pay_q[15:8];
      turn_q    <= turn_new;
      mt_q      <= mt_d;
    end
  end

  // shared multiplier operand select
  always_comb begin
    case (cmd_i.mul_op)
      mfd_pkg::MUL_SPEED:   opa = mfd_pkg::OpaW'(speed_q);
      mfd_pkg::MUL_CURRENT: opa = mfd_pkg::OpaW'(current_q);
      mfd_pkg::MUL_MT_LO:   opa = signed'({1'b0, mt_q[mfd_pkg::MtLoW-1:0]});
      mfd_pkg::MUL_MT_HI:   opa = mfd_pkg::OpaW'(signed'(mt_q[mfd_pkg::MtW-1:mfd_pkg::MtLoW]));
      default:              opa = '0;
    endcase
    if (cmd_i.mul_op == mfd_pkg::MUL_CURRENT) begin
      opb = signed'({1'b0, cfg_i.trq_gain});
    end else begin
      opb = signed'({1'b0, cfg_i.inv_ratio});
    end
  end

  // shaft speed saturation to 32 bits
  assign spd_fits = (&prod_q[mfd_pkg::ProdW-1:mfd_pkg::CfgW-1])
                    || !(|prod_q[mfd_pkg::ProdW-1:mfd_pkg::CfgW-1]);
  assign spd_sat  = spd_fits ? prod_q[mfd_pkg::CfgW-1:0]
                  : (prod_q[mfd_pkg::ProdW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

  // position: low partial plus high partial shifted up, kept to 64 bits
  assign pos_d = signed'(mfd_pkg::WideW'(plo_q))
                 + (mfd_pkg::WideW'(prod_q) <<< mfd_pkg::MtLoW);

  // multiplier register and partial results
  always_ff @(posedge clk_i) begin
    prod_q <= opa * opb;
    if (cmd_i.st_spd) spd_q <= spd_sat;
    if (cmd_i.st_trq) trq_q <= mfd_pkg::WideW'(prod_q);
    if (cmd_i.st_plo) plo_q <= prod_q[mfd_pkg::PloW-1:0];
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      if (hit_q) begin
        status_o          <= mfd_pkg::StatusDecoded;
        motor_number_o    <= num_q;
        rotor_angle_o     <= angle_q;
        rotor_speed_o     <= speed_q;
        winding_current_o <= current_q;
        temperature_o     <= temp_q;
        turn_count_o      <= turn_q;
        shaft_position_o  <= pos_d;
        shaft_speed_o     <= spd_q;
        torque_o          <= trq_q;
      end else begin
        status_o          <= mfd_pkg::StatusNotRegistered;
        motor_number_o    <= '0;
        rotor_angle_o     <= '0;
        rotor_speed_o     <= '0;
        winding_current_o <= '0;
        temperature_o     <= '0;
        turn_count_o      <= '0;
        shaft_position_o  <= '0;
        shaft_speed_o     <= '0;
        torque_o          <= '0;
      end
    end
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.fin;
    end
  end

  assign valid_o = valid_q;

endmodule

### rtl/motor_feedback_frame_decoder_top.sv
// top level of the motor feedback frame decoder
//
//   channel   handshake                      payload
//   ------    -------------------------      -----------------------------------------
//   frame in  start && !busy                 frame_id_i, payload_i
//   result    valid_o, one cycle             status_o ... torque_o
//   config    psel & penable & pwrite        paddr[3:2] selects register, pwdata
//
// a decoded item runs from accept to the next possible accept through a decode and
// turn-update step, four passes through the one shared 25x33 multiplier, a step to
// assemble results, and the result strobe, during which busy is already low.
// a frame for an unregistered motor skips the multiplier and goes from decode to assembly.
// the result shows for one cycle on valid_o; the receiver cannot stall it.
// reset clears configuration, per-motor tracking state and the controller.
`timescale 1ns / 1ps

module motor_feedback_frame_decoder_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [mfd_pkg::IdW-1:0]             frame_id_i,
  input  logic [mfd_pkg::PayloadW-1:0]        payload_i,
  output logic                                valid_o,
  output logic                                status_o,
  output logic [mfd_pkg::NumW-1:0]            motor_number_o,
  output logic signed [mfd_pkg::AngleW-1:0]   rotor_angle_o,
  output logic signed [mfd_pkg::AngleW-1:0]   rotor_speed_o,
  output logic signed [mfd_pkg::AngleW-1:0]   winding_current_o,
  output logic [mfd_pkg::TempW-1:0]           temperature_o,
  output logic signed [mfd_pkg::TurnW-1:0]    turn_count_o,
  output logic signed [mfd_pkg::WideW-1:0]    shaft_position_o,
  output logic signed [mfd_pkg::CfgW-1:0]     shaft_speed_o,
  output logic signed [mfd_pkg::WideW-1:0]    torque_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mfd_pkg::AddrW-1:0]           paddr,
  input  logic [mfd_pkg::CfgW-1:0]            pwdata,
  output logic [mfd_pkg::CfgW-1:0]            prdata,
  output logic                                pready
);

  mfd_pkg::mfd_cfg_t  cfg;
  mfd_pkg::mfd_cmd_t  cmd;
  mfd_pkg::mfd_stat_t stat;

  // configuration registers
  mfd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // controller
  mfd_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // datapath
  mfd_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .cfg_i             (cfg),
    .frame_id_i        (frame_id_i),
    .payload_i         (payload_i),
    .valid_o           (valid_o),
    .status_o          (status_o),
    .motor_number_o    (motor_number_o),
    .rotor_angle_o     (rotor_angle_o),
    .rotor_speed_o     (rotor_speed_o),
    .winding_current_o (winding_current_o),
    .temperature_o     (temperature_o),
    .turn_count_o      (turn_count_o),
    .shaft_position_o  (shaft_position_o),
    .shaft_speed_o     (shaft_speed_o),
    .torque_o          (torque_o)
  );

endmodule

### rtl/mfd_checker.sv
// port-level checker for the motor feedback frame decoder, bound to the top level
`timescale 1ns / 1ps

module mfd_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start,
  input logic                                busy,
  input logic                                valid_o,
  input logic                                status_o,
  input logic [mfd_pkg::NumW-1:0]            motor_number_o,
  input logic signed [mfd_pkg::WideW-1:0]    shaft_position_o,
  input logic signed [mfd_pkg::WideW-1:0]    torque_o
);

  // an accepted item makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // the block only goes idle by delivering a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> valid_o)
    else $error("busy fell without a result");

  // a result strobe lasts one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe longer than one cycle");

  // an unregistered motor gives zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (status_o == mfd_pkg::StatusNotRegistered)) |->
      (motor_number_o == '0) && (shaft_position_o == '0) && (torque_o == '0))
    else $error("unregistered result carries data");

  // a decoded item names a motor in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (status_o == mfd_pkg::StatusDecoded)) |->
      (motor_number_o != '0) &&
      (motor_number_o <= mfd_pkg::NumW'(mfd_pkg::MotorSlots)))
    else $error("decoded result with motor number out of range");

endmodule

bind motor_feedback_frame_decoder_top mfd_checker u_mfd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .valid_o          (valid_o),
  .status_o         (status_o),
  .motor_number_o   (motor_number_o),
  .shaft_position_o (shaft_position_o),
  .torque_o         (torque_o)
);

### dv/motor_feedback_frame_decoder_top_tb.sv
// self-checking testbench for the motor feedback frame decoder top level
`timescale 1ns / 1ps

module motor_feedback_frame_decoder_top_tb;

  localparam int NumPhases     = 8;
  localparam int ItemsPerPhase = 100;
  localparam int TailCycles    = 12;
  localparam longint SpeedMax  = 64'sd2147483647;
  localparam longint SpeedMin  = -64'sd2147483648;

  // one decoded result, fields in port order
  typedef struct packed {
    logic                              status;
    logic [mfd_pkg::NumW-1:0]          num;
    logic signed [mfd_pkg::AngleW-1:0] angle;
    logic signed [mfd_pkg::AngleW-1:0] speed;
    logic signed [mfd_pkg::AngleW-1:0] current;
    logic [mfd_pkg::TempW-1:0]         temp;
    logic signed [mfd_pkg::TurnW-1:0]  turns;
    logic signed [mfd_pkg::WideW-1:0]  position;
    logic signed [mfd_pkg::CfgW-1:0]   shaft_spd;
    logic signed [mfd_pkg::WideW-1:0]  torque;
  } decode_t;

  // expected decodes with a private copy of registers and per-motor tracking
  class feedback_scoreboard;
    logic [mfd_pkg::MaskW-1:0] reg_mask;
    logic [mfd_pkg::MaskW-1:0] rev_mask;
    logic [mfd_pkg::CfgW-1:0]  inv_ratio;
    logic [mfd_pkg::CfgW-1:0]  trq_gain;
    int                        last_ang [mfd_pkg::MotorSlots];
    logic [mfd_pkg::TurnW-1:0] turns [mfd_pkg::MotorSlots];
    logic [1:0]                last_sgn [mfd_pkg::MotorSlots];
    decode_t                   pending_decodes [$];
    int                        errors;

    function new();
      reg_mask  = '0;
      rev_mask  = '0;
      inv_ratio = mfd_pkg::InvRatioReset;
      trq_gain  = '0;
      errors    = 0;
      for (int i = 0; i < mfd_pkg::MotorSlots; i++) begin
        last_ang[i] = 0;
        turns[i]    = '0;
        last_sgn[i] = mfd_pkg::SignZero;
      end
    endfunction

    function void set_reg(logic [1:0] idx, logic [mfd_pkg::CfgW-1:0] val);
      case (idx)
        mfd_pkg::RegRegisteredMask: reg_mask  = val[mfd_pkg::MaskW-1:0];
        mfd_pkg::RegReverseMask:    rev_mask  = val[mfd_pkg::MaskW-1:0];
        mfd_pkg::RegInvRatio:       inv_ratio = val;
        mfd_pkg::RegTorqueGain:     trq_gain  = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_decodes.size();
    endfunction

    // work out the decode of an accepted frame and queue it
    function void note_frame(logic [mfd_pkg::IdW-1:0] id, logic [mfd_pkg::PayloadW-1:0] pl);
      decode_t                 r;
      logic [mfd_pkg::IdW-1:0] n;
      int                      s;
      int                      ang;
      int                      spd;
      int                      cur;
      longint                  mt;
      longint                  sp;
      r = '0;
      r.status = mfd_pkg::StatusNotRegistered;
      n = id - mfd_pkg::IdBase;
      if (n >= 1 && n <= mfd_pkg::MotorSlots && reg_mask[n-1]) begin
        s   = n - 1;
        ang = {16'd0, pl[63:48]};
        spd = int'($signed(pl[47:32]));
        cur = int'($signed(pl[31:16]));
        if (rev_mask[s]) begin
          ang = -ang;
          spd = -spd;
          cur = -cur;
        end
        // wrap detection against the stored angle and speed direction
        if (ang > last_ang[s] && last_sgn[s] == mfd_pkg::SignNeg) begin
          turns[s] = turns[s] - 1;
        end else if (ang < last_ang[s] && last_sgn[s] == mfd_pkg::SignPos) begin
          turns[s] = turns[s] + 1;
        end
        last_ang[s] = ang;
        last_sgn[s] = (spd > 0) ? mfd_pkg::SignPos
                    : ((spd < 0) ? mfd_pkg::SignNeg : mfd_pkg::SignZero);
        // fixed-point scaling
        mt = longint'($signed(turns[s])) * 8191 + ang;
        sp = longint'(spd) * longint'({32'd0, inv_ratio});
        if (sp > SpeedMax) sp = SpeedMax;
        if (sp < SpeedMin) sp = SpeedMin;
        r.status    = mfd_pkg::StatusDecoded;
        r.num       = n[mfd_pkg::NumW-1:0];
        r.angle     = ang[mfd_pkg::AngleW-1:0];
        r.speed     = spd[mfd_pkg::AngleW-1:0];
        r.current   = cur[mfd_pkg::AngleW-1:0];
        r.temp      = pl[15:8];
        r.turns     = turns[s];
        r.position  = mt * longint'({32'd0, inv_ratio});
        r.shaft_spd = sp[mfd_pkg::CfgW-1:0];
        r.torque    = longint'(cur) * longint'({32'd0, trq_gain});
      end
      pending_decodes.push_back(r);
    endfunction

    function void cmp(string name, logic [mfd_pkg::WideW-1:0] want,
                      logic [mfd_pkg::WideW-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    // compare a strobed result with the oldest expected decode
    function void check_decode(decode_t got);
      decode_t want;
      if (pending_decodes.size() == 0) begin
        $error("result with no frame outstanding");
        errors++;
        return;
      end
      want = pending_decodes.pop_front();
      cmp("status", want.status, got.status);
      cmp("motor_number", want.num, got.num);
      cmp("rotor_angle", want.angle, got.angle);
      cmp("rotor_speed", want.speed, got.speed);
      cmp("winding_current", want.current, got.current);
      cmp("temperature", want.temp, got.temp);
      cmp("turn_count", want.turns, got.turns);
      cmp("shaft_position", want.position, got.position);
      cmp("shaft_speed", want.shaft_spd, got.shaft_spd);
      cmp("torque", want.torque, got.torque);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  logic [mfd_pkg::IdW-1:0] frame_id_i;
  logic [mfd_pkg::PayloadW-1:0] payload_i;
  logic valid_o;
  logic status_o;
  logic [mfd_pkg::NumW-1:0] motor_number_o;
  logic signed [mfd_pkg::AngleW-1:0] rotor_angle_o;
  logic signed [mfd_pkg::AngleW-1:0] rotor_speed_o;
  logic signed [mfd_pkg::AngleW-1:0] winding_current_o;
  logic [mfd_pkg::TempW-1:0] temperature_o;
  logic signed [mfd_pkg::TurnW-1:0] turn_count_o;
  logic signed [mfd_pkg::WideW-1:0] shaft_position_o;
  logic signed [mfd_pkg::CfgW-1:0] shaft_speed_o;
  logic signed [mfd_pkg::WideW-1:0] torque_o;
  logic psel;
  logic penable;
  logic pwrite;
  logic [mfd_pkg::AddrW-1:0] paddr;
  logic [mfd_pkg::CfgW-1:0] pwdata;
  logic [mfd_pkg::CfgW-1:0] prdata;
  logic pready;

  feedback_scoreboard sb = new();

  // sender pacing and per-motor trajectory used to build well-formed frames
  bit sending = 1'b0;
  int gap_next = 0;
  int streak = 0;
  int stim_ang [1:mfd_pkg::MotorSlots] = '{default: 0};
  int stim_dir [1:mfd_pkg::MotorSlots] = '{default: 1};

  motor_feedback_frame_decoder_top uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .frame_id_i       (frame_id_i),
    .payload_i        (payload_i),
    .valid_o          (valid_o),
    .status_o         (status_o),
    .motor_number_o   (motor_number_o),
    .rotor_angle_o    (rotor_angle_o),
    .rotor_speed_o    (rotor_speed_o),
    .winding_current_o(winding_current_o),
    .temperature_o    (temperature_o),
    .turn_count_o     (turn_count_o),
    .shaft_position_o (shaft_position_o),
    .shaft_speed_o    (shaft_speed_o),
    .torque_o         (torque_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #2 clk_i = ~clk_i;

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && valid_o === 1'b1) begin
      sb.check_decode({status_o, motor_number_o, rotor_angle_o, rotor_speed_o,
                       winding_current_o, temperature_o, turn_count_o, shaft_position_o,
                       shaft_speed_o, torque_o});
    end
  end

  // mostly short gaps, a few long ones, and stretches of back-to-back items
  function automatic int pick_gap();
    int r;
    if (streak > 0) begin
      streak--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) streak = 30;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [mfd_pkg::PayloadW-1:0] pack_frame(logic [15:0] ang,
                                                              logic [15:0] spd,
                                                              logic [15:0] cur,
                                                              logic [7:0] temp,
                                                              logic [7:0] spare);
    return {ang, spd, cur, temp, spare};
  endfunction

  task automatic send_frame(logic [mfd_pkg::IdW-1:0] id, logic [mfd_pkg::PayloadW-1:0] pl);
    if (!sending) repeat ((gap_next > 0) ? gap_next : 1) @(posedge clk_i);
    frame_id_i <= id;
    payload_i  <= pl;
    start      <= 1'b1;
    sending = 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_frame(id, pl);
    gap_next = pick_gap();
    if (gap_next != 0) begin
      start <= 1'b0;
      sending = 1'b0;
    end
  endtask

  task automatic stop_sender();
    if (sending) begin
      start <= 1'b0;
      sending = 1'b0;
    end
  endtask

  // hold off until every expected decode has come back
  task automatic drain();
    stop_sender();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // back-to-back writes keep psel high; the caller closes the transfer
  task automatic write_reg(logic [1:0] idx, logic [mfd_pkg::CfgW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    sb.set_reg(idx, val);
  endtask

  task automatic configure(logic [mfd_pkg::MaskW-1:0] rm, logic [mfd_pkg::MaskW-1:0] vm,
                           logic [mfd_pkg::CfgW-1:0] ir, logic [mfd_pkg::CfgW-1:0] tg);
    write_reg(mfd_pkg::RegRegisteredMask, {24'd0, rm});
    write_reg(mfd_pkg::RegReverseMask, {24'd0, vm});
    write_reg(mfd_pkg::RegInvRatio, ir);
    write_reg(mfd_pkg::RegTorqueGain, tg);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // random frame: mostly trajectories that wrap, plus raw payloads and stray ids
  task automatic make_frame(output logic [mfd_pkg::IdW-1:0] id,
                            output logic [mfd_pkg::PayloadW-1:0] pl);
    int m;
    int step;
    int v;
    int r;
    r  = $urandom_range(0, 99);
    m  = $urandom_range(1, mfd_pkg::MotorSlots);
    id = mfd_pkg::IdBase + mfd_pkg::IdW'(m);
    pl = {$urandom, $urandom};
    if (r < 15) begin
      id = mfd_pkg::IdW'($urandom_range(0, 2047));
    end else if (r >= 25) begin
      if ($urandom_range(0, 9) == 0) stim_dir[m] = -stim_dir[m];
      step = $urandom_range(1, 3000);
      stim_ang[m] = ((stim_ang[m] + stim_dir[m] * step) % 8192 + 8192) % 8192;
      v = $urandom_range(1, 32767);
      if ($urandom_range(0, 9) == 0) v = 0;
      v = stim_dir[m] * v;
      pl[63:48] = stim_ang[m][15:0];
      pl[47:32] = v[15:0];
    end
  endtask

  // corner frames: stray ids, masked motors, extremes, every turn-count rule
  task automatic run_directed();
    send_frame(11'h000, '1);
    send_frame(mfd_pkg::IdBase, '0);
    send_frame(mfd_pkg::IdBase + 11'd9, {$urandom, $urandom});
    send_frame(11'h7FF, {$urandom, $urandom});
    send_frame(mfd_pkg::IdBase + 11'd5, {$urandom, $urandom});
    send_frame(mfd_pkg::IdBase + 11'd1,
               pack_frame(16'hFFFF, 16'h7FFF, 16'h8000, 8'hFF, 8'h00));
    send_frame(mfd_pkg::IdBase + 11'd1,
               pack_frame(16'h0000, 16'h8000, 16'h7FFF, 8'h00, 8'hFF));
    send_frame(mfd_pkg::IdBase + 11'd1,
               pack_frame(16'h0001, 16'h0000, 16'h0000, 8'h5A, 8'hA5));
    send_frame(mfd_pkg::IdBase + 11'd6,
               pack_frame(16'd8000, 16'd1000, 16'd1234, 8'd25, 8'h00));
    send_frame(mfd_pkg::IdBase + 11'd6,
               pack_frame(16'd100, 16'd1000, -16'sd1234, 8'd26, 8'h00));
    send_frame(mfd_pkg::IdBase + 11'd6, pack_frame(16'd50, -16'sd5, 16'd0, 8'd27, 8'h00));
    send_frame(mfd_pkg::IdBase + 11'd6, pack_frame(16'd60, -16'sd5, 16'd0, 8'd27, 8'h00));
    send_frame(mfd_pkg::IdBase + 11'd6, pack_frame(16'd60, 16'd0, 16'd0, 8'd28, 8'h00));
    send_frame(mfd_pkg::IdBase + 11'd6, pack_frame(16'd10, 16'd0, 16'd0, 8'd28, 8'h00));
    send_frame(mfd_pkg::IdBase + 11'd6, pack_frame(16'd20, 16'd0, 16'd0, 8'd28, 8'h00));
    send_frame(mfd_pkg::IdBase + 11'd6,
               pack_frame(16'hFFFF, 16'h7FFF, 16'h7FFF, 8'hFF, 8'hFF));
    send_frame(mfd_pkg::IdBase + 11'd6,
               pack_frame(16'h0000, 16'h8000, 16'h8000, 8'h00, 8'h00));
    send_frame(mfd_pkg::IdBase + 11'd8, '0);
    send_frame(mfd_pkg::IdBase + 11'd8, '1);
    send_frame(mfd_pkg::IdBase + 11'd2, pack_frame(16'd0, 16'd1, 16'd1, 8'd1, 8'd1));
    send_frame(mfd_pkg::IdBase + 11'd5, '1);
  endtask

  // run limit
  initial begin
    #2ms;
    $display("motor_feedback_frame_decoder_top_tb NOT OK");
    $finish;
  end

  // main sequence
  initial begin
    logic [mfd_pkg::IdW-1:0]      id;
    logic [mfd_pkg::PayloadW-1:0] pl;
    logic [mfd_pkg::MaskW-1:0]    rm;
    logic [mfd_pkg::MaskW-1:0]    vm;
    logic [mfd_pkg::CfgW-1:0]     ir;
    logic [mfd_pkg::CfgW-1:0]     tg;
    rst_ni     <= 1'b0;
    start      <= 1'b0;
    frame_id_i <= '0;
    payload_i  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < NumPhases; ph++) begin
      rm = mfd_pkg::MaskW'($urandom);
      vm = mfd_pkg::MaskW'($urandom);
      tg = $urandom >> $urandom_range(0, 31);
      case ($urandom_range(0, 3))
        0:       ir = mfd_pkg::InvRatioReset;
        1:       ir = $urandom_range(1, 65535);
        2:       ir = $urandom;
        default: ir = $urandom_range(65536, 1 << 20);
      endcase
      // fixed settings cover the register extremes
      case (ph)
        0: begin rm = 8'hAF; vm = 8'h0F; ir = '1; tg = '1; end
        1: begin rm = 8'hFF; vm = 8'h00; ir = '0; tg = '0; end
        2: begin rm = 8'hFF; vm = 8'hFF; ir = 32'd1; tg = '1; end
        3: begin rm = 8'h00; vm = 8'h55; ir = mfd_pkg::InvRatioReset; tg = 32'h0100_0000; end
        default: ;
      endcase
      drain();
      configure(rm, vm, ir, tg);
      if (ph == 0) begin
        run_directed();
      end else begin
        repeat (ItemsPerPhase) begin
          make_frame(id, pl);
          send_frame(id, pl);
          if ($urandom_range(0, 99) == 0) drain();
        end
      end
    end

    drain();
    repeat (TailCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("motor_feedback_frame_decoder_top_tb OK");
    end else begin
      $display("motor_feedback_frame_decoder_top_tb NOT OK");
    end
    $finish;
  end

endmodule
